FILE: rtl/qss_pkg.sv
// Shared constants for the quadrilateral scan-line span block.
`timescale 1ns / 1ps
package qss_pkg;
  localparam int unsigned NumVerts = 4;
  localparam int unsigned NumEdges = 4;
  localparam int unsigned Canvas   = 512;

  localparam logic [3:0] RegV0X = 4'd0;
  localparam logic [3:0] RegV0Y = 4'd1;
  localparam logic [3:0] RegV1X = 4'd2;
  localparam logic [3:0] RegV1Y = 4'd3;
  localparam logic [3:0] RegV2X = 4'd4;
  localparam logic [3:0] RegV2Y = 4'd5;
  localparam logic [3:0] RegV3X = 4'd6;
  localparam logic [3:0] RegV3Y = 4'd7;

  localparam int unsigned EdgeA [NumEdges] = '{0, 1, 3, 0};
  localparam int unsigned EdgeB [NumEdges] = '{1, 2, 2, 3};
endpackage

FILE: rtl/qss_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module qss_divider import qss_pkg::*; #(
  parameter int unsigned NW = 19,
  parameter int unsigned DW = 9,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  logic            vld_q [1:NW];
  logic [NW-1:0]   quo_q [1:NW];
  logic [DW-1:0]   rem_q [1:NW];
  logic [NW-1:0]   num_q [1:NW];
  logic [DW-1:0]   den_q [1:NW];
  logic [TW-1:0]   tag_q [1:NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_in;
    logic [NW-1:0] quo_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   trial;
    logic          ge;
    if (s == 0) begin : g_head
      assign vld_in = valid_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_body
      assign vld_in = vld_q[s];
      assign quo_in = quo_q[s];
      assign rem_in = rem_q[s];
      assign num_in = num_q[s];
      assign den_in = den_q[s];
      assign tag_in = tag_q[s];
    end
    assign trial = {rem_in, num_in[NW-1-s]};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        quo_q[s+1] <= quo_in | (NW'(ge) << (NW-1-s));
        num_q[s+1] <= num_in;
        den_q[s+1] <= den_in;
        tag_q[s+1] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = quo_q[NW];
  assign tag_o   = tag_q[NW];
endmodule

FILE: rtl/quad_scanline_span.sv
// Top level: scan-line span of a configured quadrilateral.
`timescale 1ns / 1ps
// Usage: write the eight vertex coordinates on the cfg channel (index 0..7:
// v0x v0y v1x v1y v2x v2y v3x v3y) while idle; other indexes are ignored.
// Each row_i item on the input channel yields one span item on the output.
// Throughput is one item per cycle while the output is not stalled. The stages are
// edge math, crossing compare and min/max, then one divider stage per quotient bit
// (19 stages), then the output register.
// The whole pipeline advances only when the output register is free or
// being taken, so a stalled receiver holds every stage; in_ready_o drops.
// Reset clears all valid bits and zeroes the vertex registers.
// A row at or beyond the canvas gives an empty span (all fields zero).
module quad_scanline_span import qss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [8:0] row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [8:0] span_first_o,
  output logic [8:0] span_last_o,
  output logic       span_nonempty_o
);
  localparam int unsigned CW = 9;
  localparam int unsigned NW = 2 * CW + 1;
  localparam int unsigned PW = NW + CW;

  logic [CW-1:0] vx_q [NumVerts];
  logic [CW-1:0] vy_q [NumVerts];

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumVerts; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegV0X: vx_q[0] <= cfg_data_i;
        RegV0Y: vy_q[0] <= cfg_data_i;
        RegV1X: vx_q[1] <= cfg_data_i;
        RegV1Y: vy_q[1] <= cfg_data_i;
        RegV2X: vx_q[2] <= cfg_data_i;
        RegV2Y: vy_q[2] <= cfg_data_i;
        RegV3X: vx_q[3] <= cfg_data_i;
        RegV3Y: vy_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: orient edges, coverage, deltas
  logic               v1_q;
  logic [NumEdges-1:0] cov1_q;
  logic [CW-1:0]      xlo1_q [NumEdges];
  logic [CW-1:0]      d1_q [NumEdges];
  logic [CW-1:0]      t1_q [NumEdges];
  logic signed [CW:0] dx1_q [NumEdges];
  // stage 2: products
  logic               v2_q;
  logic [NumEdges-1:0] cov2_q;
  logic [CW-1:0]      d2_q [NumEdges];
  logic [2*CW-1:0]    p2_q [NumEdges];
  logic signed [2*CW+1:0] q2_q [NumEdges];
  // stage 3: numerators
  logic               v3_q;
  logic [NumEdges-1:0] cov3_q;
  logic [CW-1:0]      d3_q [NumEdges];
  logic [NW-1:0]      n3_q [NumEdges];
  // stages 4,5: pairwise min/max; stage 6: final compare
  logic               v4_q, v5_q, v6_q;
  logic [1:0]         h4_q;
  logic [NW-1:0]      ln4_q [2], rn4_q [2];
  logic [CW-1:0]      ld4_q [2], rd4_q [2];
  logic               h5_q;
  logic [NW-1:0]      ln5_q, rn5_q;
  logic [CW-1:0]      ld5_q, rd5_q;
  logic               ne6_q;
  logic [NW-1:0]      ln6_q, rn6_q;
  logic [CW-1:0]      ld6_q, rd6_q;

  logic row_ok;
  assign row_ok = 32'(row_i) < Canvas;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  for (genvar e = 0; e < NumEdges; e++) begin : g_edge
    logic [CW-1:0] ya, yb, xa, xb, ylo, yhi, xlo, xhi;
    logic          up;
    assign xa  = vx_q[EdgeA[e]];
    assign ya  = vy_q[EdgeA[e]];
    assign xb  = vx_q[EdgeB[e]];
    assign yb  = vy_q[EdgeB[e]];
    assign up  = ya < yb;
    assign ylo = up ? ya : yb;
    assign yhi = up ? yb : ya;
    assign xlo = up ? xa : xb;
    assign xhi = up ? xb : xa;
    always_ff @(posedge clk_i) begin
      if (en) begin
        cov1_q[e] <= row_ok && (ya != yb) && (row_i >= ylo) && (row_i < yhi);
        xlo1_q[e] <= xlo;
        d1_q[e]   <= yhi - ylo;
        t1_q[e]   <= row_i - ylo;
        dx1_q[e]  <= $signed({1'b0, xhi}) - $signed({1'b0, xlo});
        cov2_q[e] <= cov1_q[e];
        d2_q[e]   <= d1_q[e];
        p2_q[e]   <= xlo1_q[e] * d1_q[e];
        q2_q[e]   <= $signed({1'b0, t1_q[e]}) * dx1_q[e];
        cov3_q[e] <= cov2_q[e];
        d3_q[e]   <= d2_q[e];
        n3_q[e]   <= NW'($signed({2'b0, p2_q[e]}) + q2_q[e]);
      end
    end
  end

  function automatic logic lt(input logic [NW-1:0] an, input logic [CW-1:0] ad,
                              input logic [NW-1:0] bn, input logic [CW-1:0] bd);
    logic [PW-1:0] l, r;
    l = an * bd;
    r = bn * ad;
    return l < r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        logic ca, cb, a_lt, b_lt;
        ca = cov3_q[2*k];
        cb = cov3_q[2*k+1];
        a_lt = lt(n3_q[2*k], d3_q[2*k], n3_q[2*k+1], d3_q[2*k+1]);
        b_lt = lt(n3_q[2*k+1], d3_q[2*k+1], n3_q[2*k], d3_q[2*k]);
        h4_q[k] <= ca || cb;
        if (ca && (!cb || !b_lt)) begin
          ln4_q[k] <= n3_q[2*k];   ld4_q[k] <= d3_q[2*k];
        end else begin
          ln4_q[k] <= n3_q[2*k+1]; ld4_q[k] <= d3_q[2*k+1];
        end
        if (ca && (!cb || !a_lt)) begin
          rn4_q[k] <= n3_q[2*k];   rd4_q[k] <= d3_q[2*k];
        end else begin
          rn4_q[k] <= n3_q[2*k+1]; rd4_q[k] <= d3_q[2*k+1];
        end
      end
      h5_q <= h4_q[0] || h4_q[1];
      if (h4_q[0] && (!h4_q[1] || !lt(ln4_q[1], ld4_q[1], ln4_q[0], ld4_q[0]))) begin
        ln5_q <= ln4_q[0]; ld5_q <= ld4_q[0];
      end else begin
        ln5_q <= ln4_q[1]; ld5_q <= ld4_q[1];
      end
      if (h4_q[0] && (!h4_q[1] || !lt(rn4_q[0], rd4_q[0], rn4_q[1], rd4_q[1]))) begin
        rn5_q <= rn4_q[0]; rd5_q <= rd4_q[0];
      end else begin
        rn5_q <= rn4_q[1]; rd5_q <= rd4_q[1];
      end
      ne6_q <= h5_q && lt(ln5_q, ld5_q, rn5_q, rd5_q);
      ln6_q <= ln5_q;
      ld6_q <= ld5_q;
      rn6_q <= NW'(rn5_q + NW'(rd5_q) - NW'(1));
      rd6_q <= rd5_q;
    end
  end

  logic          dl_v, dr_v;
  logic [NW-1:0] ql, qr;
  logic          ne_l, ne_r;

  qss_divider #(.NW(NW), .DW(CW), .TW(1)) u_div_first (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q),
    .num_i(ln6_q), .den_i(ld6_q), .tag_i(ne6_q),
    .valid_o(dl_v), .quo_o(ql), .tag_o(ne_l)
  );
  qss_divider #(.NW(NW), .DW(CW), .TW(1)) u_div_last (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q),
    .num_i(rn6_q), .den_i(rd6_q), .tag_i(ne6_q),
    .valid_o(dr_v), .quo_o(qr), .tag_o(ne_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dl_v && dr_v;
    end
  end

  logic [CW-1:0] first_q, last_q;
  logic          ne_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ne_q    <= ne_l && ne_r;
      first_q <= ne_l ? ql[CW-1:0] : '0;
      last_q  <= ne_r ? CW'(qr[CW-1:0] - CW'(1)) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign span_first_o    = first_q;
  assign span_last_o     = last_q;
  assign span_nonempty_o = ne_q;
endmodule

FILE: tb/sv/quad_scanline_span_tb.sv
// Testbench for quad_scanline_span: random and directed rows checked against a span predictor.
`timescale 1ns / 1ps
module quad_scanline_span_tb;
  import qss_pkg::*;

  typedef struct packed {
    logic [8:0] first;
    logic [8:0] last;
    logic       nonempty;
  } span_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [8:0] row_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [8:0] span_first_o;
  logic [8:0] span_last_o;
  logic       span_nonempty_o;

  quad_scanline_span u_dut (.*);

  always #10 clk_i = ~clk_i;

  logic [8:0] quad_x [NumVerts];
  logic [8:0] quad_y [NumVerts];
  logic [8:0] pending_rows [$];
  span_t      span_queue [$];
  logic       row_taken = 1'b0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         errors = 0;
  int         rows_sent = 0;
  int         spans_seen = 0;
  int         filled_rows = 0;
  int         quiet_cycles = 0;

  function automatic span_t span_for_row(logic [8:0] r);
    span_t s;
    bit have;
    longint ln, ld, rn, rd, xlo, ylo, xhi, yhi, d, n, row;
    int a, b;
    s = '0;
    have = 0;
    ln = 0; ld = 1; rn = 0; rd = 1;
    row = r;
    for (int e = 0; e < NumEdges; e++) begin
      a = EdgeA[e];
      b = EdgeB[e];
      if (quad_y[a] == quad_y[b]) continue;
      if (quad_y[a] < quad_y[b]) begin
        xlo = quad_x[a]; ylo = quad_y[a]; xhi = quad_x[b]; yhi = quad_y[b];
      end else begin
        xlo = quad_x[b]; ylo = quad_y[b]; xhi = quad_x[a]; yhi = quad_y[a];
      end
      if (row < ylo || row >= yhi) continue;
      d = yhi - ylo;
      n = xlo * d + (row - ylo) * (xhi - xlo);
      if (!have) begin
        ln = n; ld = d; rn = n; rd = d;
        have = 1;
      end else begin
        if (n * ld < ln * d) begin ln = n; ld = d; end
        if (n * rd > rn * d) begin rn = n; rd = d; end
      end
    end
    if (have && ln * rd < rn * ld) begin
      s.first = 9'(ln / ld);
      s.last = 9'((rn + rd - 1) / rd - 1);
      s.nonempty = 1'b1;
    end
    return s;
  endfunction

  task automatic report(string what, logic [8:0] got, logic [8:0] want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || row_taken) begin
        if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          row_i <= pending_rows.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    span_t want;
    row_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        span_queue.push_back(span_for_row(row_i));
        rows_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        spans_seen++;
        if (span_queue.size() == 0) begin
          errors++;
          $display("MISMATCH unexpected span at %0t", $realtime);
        end else begin
          want = span_queue.pop_front();
          if (want.nonempty) filled_rows++;
          if (span_first_o !== want.first) report("span_first", span_first_o, want.first);
          if (span_last_o !== want.last) report("span_last", span_last_o, want.last);
          if (span_nonempty_o !== want.nonempty)
            report("span_nonempty", 9'(span_nonempty_o), 9'(want.nonempty));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("Timeout: no item moved for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [8:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= RegV3Y) begin
      if (idx[0]) quad_y[idx >> 1] = data;
      else quad_x[idx >> 1] = data;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_quad(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
    write_reg(RegV0X, 9'(x0)); write_reg(RegV0Y, 9'(y0));
    write_reg(RegV1X, 9'(x1)); write_reg(RegV1Y, 9'(y1));
    write_reg(RegV2X, 9'(x2)); write_reg(RegV2Y, 9'(y2));
    write_reg(RegV3X, 9'(x3)); write_reg(RegV3Y, 9'(y3));
    // out-of-range index must be ignored
    write_reg(4'(RegV3Y + 1 + $urandom_range(7)), 9'($urandom));
  endtask

  task automatic drain();
    wait (pending_rows.size() == 0 && !in_valid_i && span_queue.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic random_rows(int count);
    int ymin, ymax;
    ymin = 511; ymax = 0;
    for (int v = 0; v < NumVerts; v++) begin
      if (quad_y[v] < ymin) ymin = quad_y[v];
      if (quad_y[v] > ymax) ymax = quad_y[v];
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) pending_rows.push_back(9'($urandom_range(ymax, ymin)));
      else pending_rows.push_back(9'($urandom));
    end
  endtask

  initial begin
    for (int v = 0; v < NumVerts; v++) begin
      quad_x[v] = '0;
      quad_y[v] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset vertices: everything degenerate
    pending_rows = '{9'd0, 9'd1, 9'd511};
    drain();

    // full canvas, extreme coordinates, vertical edges, horizontal edges
    set_quad(0, 0, 511, 0, 511, 511, 0, 511);
    pending_rows = '{9'd0, 9'd1, 9'd255, 9'd510, 9'd511, 9'h155, 9'h0AA};
    drain();
    // downward edges, slanted, non-integer crossings
    set_quad(300, 500, 10, 3, 77, 250, 511, 20);
    pending_rows = '{9'd2, 9'd3, 9'd4, 9'd19, 9'd20, 9'd21, 9'd249, 9'd250, 9'd499, 9'd500};
    drain();
    // collapsed to a line: never two distinct crossings
    set_quad(100, 10, 100, 400, 100, 10, 100, 400);
    pending_rows = '{9'd10, 9'd200, 9'd399, 9'd400};
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 76; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 76; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      if (ph == 11) set_quad(511, 511, 511, 0, 0, 0, 0, 511);
      else if (ph == 10) set_quad(0, 0, 0, 511, 511, 511, 511, 0);
      else set_quad($urandom_range(511), $urandom_range(511), $urandom_range(511),
                    $urandom_range(511), $urandom_range(511), $urandom_range(511),
                    $urandom_range(511), $urandom_range(511));
      random_rows(100);
      drain();
    end

    repeat (60) @(posedge clk_i);
    $display("Checked %0d rows (%0d with a filled span) over 16 vertex settings,", rows_sent,
             filled_rows);
    $display("with sender gaps and receiver stalls; %0d spans received.", spans_seen);
    if (errors == 0 && span_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/qss_pkg.sv
rtl/qss_divider.sv
rtl/quad_scanline_span.sv
tb/sv/quad_scanline_span_tb.sv
